/* src/assert_macros.svh */
// assertion macros shared by the alu rtl
// no dependencies; bodies compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* src/fpa_pkg.sv */
// shared types, opcodes and helpers for the fixed-point alu
// no dependencies
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int QUO_W          = 34;
    localparam int DIV_BITS_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / DIV_BITS_STAGE;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_INC     = 4'd4,
        OP_DEC     = 4'd5,
        OP_MIN     = 4'd6,
        OP_MAX     = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT  = 4'd9
    } alu_op_t;

    typedef enum logic [1:0] {
        SEL_SIMPLE = 2'd0,
        SEL_MUL    = 2'd1,
        SEL_DIV    = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } alu_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               less;
        logic               equal;
        logic               greater;
        logic               error;
    } alu_out_t;

    // payload carried down the pipeline
    typedef struct packed {
        res_sel_t           sel;
        logic               less;
        logic               equal;
        logic               greater;
        logic [31:0]        simple_res;
        logic               simple_err;
        logic               neg;
        logic [63:0]        prod;
        logic [31:0]        rem;
        logic [QUO_W-1:0]   num;
        logic [QUO_W-1:0]   quo;
        logic [31:0]        dvs;
        logic               ovf;
    } pipe_t;

    // sign and magnitude to saturated 32-bit value, error flag on top
    function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (neg && (mag != 64'd0)) begin
            if (mag > 64'h0000_0000_8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, (~mag[31:0]) + 32'd1};
        end
        else begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/fpa_div_step.sv */
// one pipeline stage of the restoring divider, DIV_BITS_STAGE (2) quotient bits per stage
// depends on fpa_pkg
`default_nettype none
module fpa_div_step
    import fpa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire pipe_t in_data,
    output logic       out_valid,
    output pipe_t      out_data
);

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    // shift in numerator bits, subtract divisor where it fits
    always_comb
    begin
        logic [32:0] trial;
        data_next = in_data;
        trial     = '0;
        for (int i = 0; i < DIV_BITS_STAGE; i++)
        begin
            trial = {data_next.rem, data_next.num[QUO_W-1]};
            data_next.num = {data_next.num[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, data_next.dvs})
            begin
                trial = trial - {1'b0, data_next.dvs};
                data_next.quo = {data_next.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                data_next.quo = {data_next.quo[QUO_W-2:0], 1'b0};
            end
            data_next.rem = trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* src/fixed_point_alu_core.sv */
// fixed-point alu: input register, decode register, divider pipeline and output register
// throughput one transfer per cycle while the output is not stalled; the 17-stage divider pipeline sets the depth
// each stage holds its item only while the stage after it is full and stalled
// rst_n clears all valid bits asynchronously; payload registers are not reset
// depends on fpa_pkg, fpa_div_step and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu_core
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire alu_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output alu_out_t     out_data
);

    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    logic     s1_valid_reg;
    alu_in_t  s1_reg;
    logic     s2_valid_reg;
    pipe_t    s2_reg;
    pipe_t    s2_next;
    logic     out_valid_reg;
    alu_out_t out_reg;
    alu_out_t out_next;

    logic en_s1, en_s2, en_out;
    logic  [DIV_STAGES-1:0] dv;
    logic  [DIV_STAGES-1:0] en_div;
    pipe_t dd [DIV_STAGES];

    // stall chain, each stage moves if empty or downstream moves
    assign en_out   = !out_valid_reg || out_ready;
    assign en_s2    = !s2_valid_reg || en_div[0];
    assign en_s1    = !s1_valid_reg || en_s2;
    assign in_ready = en_s1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en_s1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && in_valid)
            s1_reg <= in_data;
    end

    // decode, simple ops, multiply and divider setup
    always_comb
    begin
        logic [31:0] mag_a, mag_b;
        logic [32:0] sum;
        logic [63:0] numer;
        logic [63:0] hi;
        mag_a = s1_reg.operand_a[31] ? (~s1_reg.operand_a) + 32'd1 : s1_reg.operand_a;
        mag_b = s1_reg.operand_b[31] ? (~s1_reg.operand_b) + 32'd1 : s1_reg.operand_b;
        numer = {32'd0, mag_a} << FRAC_BITS;
        hi    = numer >> QUO_W;
        sum   = '0;

        s2_next            = '0;
        s2_next.sel        = SEL_SIMPLE;
        s2_next.less       = s1_reg.operand_a < s1_reg.operand_b;
        s2_next.equal      = s1_reg.operand_a == s1_reg.operand_b;
        s2_next.greater    = s1_reg.operand_a > s1_reg.operand_b;
        s2_next.neg        = s1_reg.operand_a[31] ^ s1_reg.operand_b[31];
        s2_next.prod       = {32'd0, mag_a} * {32'd0, mag_b};
        s2_next.dvs        = mag_b;
        s2_next.ovf        = hi >= {32'd0, mag_b};
        s2_next.rem        = hi[31:0];
        s2_next.num        = numer[QUO_W-1:0];
        s2_next.quo        = '0;

        case (alu_op_t'(s1_reg.kind))
            OP_ADD, OP_SUB, OP_INC, OP_DEC:
            begin
                case (alu_op_t'(s1_reg.kind))
                    OP_ADD:  sum = {s1_reg.operand_a[31], s1_reg.operand_a}
                                 + {s1_reg.operand_b[31], s1_reg.operand_b};
                    OP_SUB:  sum = {s1_reg.operand_a[31], s1_reg.operand_a}
                                 - {s1_reg.operand_b[31], s1_reg.operand_b};
                    OP_INC:  sum = {s1_reg.operand_a[31], s1_reg.operand_a} + 33'd1;
                    default: sum = {s1_reg.operand_a[31], s1_reg.operand_a} - 33'd1;
                endcase
                if (sum[32] != sum[31])
                begin
                    s2_next.simple_err = 1'b1;
                    s2_next.simple_res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    s2_next.simple_res = sum[31:0];
                end
            end
            OP_MUL:
                s2_next.sel = SEL_MUL;
            OP_DIV:
            begin
                if (mag_b == 32'd0)
                    s2_next.simple_err = 1'b1;
                else
                    s2_next.sel = SEL_DIV;
            end
            OP_MIN:
                s2_next.simple_res = (s1_reg.operand_a < s1_reg.operand_b)
                                   ? s1_reg.operand_a : s1_reg.operand_b;
            OP_MAX:
                s2_next.simple_res = (s1_reg.operand_a > s1_reg.operand_b)
                                   ? s1_reg.operand_a : s1_reg.operand_b;
            OP_FROM_INT:
                {s2_next.simple_err, s2_next.simple_res} =
                    sat_sm(s1_reg.operand_a[31], numer);
            OP_TO_INT:
                {s2_next.simple_err, s2_next.simple_res} =
                    sat_sm(s1_reg.operand_a[31], {32'd0, mag_a >> FRAC_BITS});
            default:
                s2_next.simple_err = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en_s2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_s2 && s1_valid_reg)
            s2_reg <= s2_next;
    end

    // divider pipeline
    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            if (k == DIV_STAGES - 1)
            begin : g_last
                assign en_div[k] = !dv[k] || en_out;
            end
            else
            begin : g_mid
                assign en_div[k] = !dv[k] || en_div[k+1];
            end
            if (k == 0)
            begin : g_first
                fpa_div_step u_step (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en_div[k]),
                    .in_valid  (s2_valid_reg),
                    .in_data   (s2_reg),
                    .out_valid (dv[k]),
                    .out_data  (dd[k])
                );
            end
            else
            begin : g_next
                fpa_div_step u_step (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en_div[k]),
                    .in_valid  (dv[k-1]),
                    .in_data   (dd[k-1]),
                    .out_valid (dv[k]),
                    .out_data  (dd[k])
                );
            end
        end
    endgenerate

    // rounding, saturation and result select
    always_comb
    begin
        pipe_t       p;
        logic [63:0] mmag;
        logic [63:0] dmag;
        logic [32:0] mres;
        logic [32:0] dres;
        p    = dd[DIV_STAGES-1];
        mmag = (p.prod + HALF) >> FRAC_BITS;
        dmag = {{(64-QUO_W){1'b0}}, p.quo}
             + (({p.rem, 1'b0} >= {1'b0, p.dvs}) ? 64'd1 : 64'd0);
        if (p.ovf)
            dmag = '1;
        mres = sat_sm(p.neg, mmag);
        dres = sat_sm(p.neg, dmag);

        out_next.less    = p.less;
        out_next.equal   = p.equal;
        out_next.greater = p.greater;
        case (p.sel)
            SEL_MUL:
            begin
                out_next.result = mres[31:0];
                out_next.error  = mres[32];
            end
            SEL_DIV:
            begin
                out_next.result = dres[31:0];
                out_next.error  = dres[32];
            end
            default:
            begin
                out_next.result = p.simple_res;
                out_next.error  = p.simple_err;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= dv[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en_out && dv[DIV_STAGES-1])
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    `FPA_ASSERT(a_stall_from_out, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "input stalled without output backpressure")
    `FPA_ASSERT(a_flags_onehot, clk, rst_n, out_valid |-> $onehot({out_data.less, out_data.equal, out_data.greater}), "compare flags not exclusive")
    `FPA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "output changed while stalled")

endmodule
`default_nettype wire
